>>> hw/rtl/bmd_pkg.sv
`default_nettype none
// ============================================================================
// BLE-MIDI packet decoder package
// Shared types, byte codes and the data byte count lookup.
// ============================================================================
package bmd_pkg;

   // Most MIDI bytes that one packet byte can release.
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Result queue sizing.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   // Byte codes.
   localparam logic [7:0] LAST_TWO_DATA_CHAN = 8'hBF;
   localparam logic [7:0] LAST_ONE_DATA_CHAN = 8'hDF;
   localparam logic [7:0] LAST_CHAN_STATUS   = 8'hEF;
   localparam logic [7:0] SYSEX_START        = 8'hF0;
   localparam logic [7:0] TIME_CODE_QF       = 8'hF1;
   localparam logic [7:0] SONG_POSITION      = 8'hF2;
   localparam logic [7:0] SONG_SELECT        = 8'hF3;
   localparam logic [7:0] SYSEX_END          = 8'hF7;

   // Data byte count codes.
   localparam logic [1:0] DCNT_NONE  = 2'd0;
   localparam logic [1:0] DCNT_ONE   = 2'd1;
   localparam logic [1:0] DCNT_TWO   = 2'd2;
   localparam logic [1:0] DCNT_SYSEX = 2'd3;

   // Parser phase, one-hot.
   typedef enum logic [6:0] {
      PH_HEADER    = 7'b0000001,
      PH_DROP      = 7'b0000010,
      PH_TSTAMP    = 7'b0000100,
      PH_STATUS    = 7'b0001000,
      PH_DATA      = 7'b0010000,
      PH_RS_SECOND = 7'b0100000,
      PH_SYSEX     = 7'b1000000
   } phase_type;

   // Bytes released by one packet byte, in order.
   typedef struct packed {
      logic [RES_CNT_W-1:0]          count;
      logic [MAX_RESULTS-1:0][7:0]   bytes;
   } result_bundle_type;

   // Result queue status toward the top level.
   typedef struct packed {
      logic [FIFO_LVL_W-1:0] level;
      logic                  room;
   } fifo_status_type;

   // Number of data bytes that follow a status byte.
   function automatic logic [1:0] data_count(input logic [7:0] s);
      logic [1:0] n;
      if (s <= LAST_TWO_DATA_CHAN)      n = DCNT_TWO;
      else if (s <= LAST_ONE_DATA_CHAN) n = DCNT_ONE;
      else if (s <= LAST_CHAN_STATUS)   n = DCNT_TWO;
      else if (s == SYSEX_START)        n = DCNT_SYSEX;
      else if (s == TIME_CODE_QF || s == SONG_SELECT) n = DCNT_ONE;
      else if (s == SONG_POSITION)      n = DCNT_TWO;
      else                              n = DCNT_NONE;
      return n;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ble_midi_packet_decoder_top.sv
`default_nettype none
// ============================================================================
// BLE-MIDI packet decoder
// Turns BLE-MIDI notification packets into a plain MIDI byte stream.
// ============================================================================
// Usage:
//   The req channel carries one packet byte per beat, header first, with
//   req_packet_end set on the packet's final byte. The rsp channel returns
//   decoded MIDI bytes; rsp_last_of_run marks the last byte released by one
//   packet byte. A packet byte may release zero to three MIDI bytes.
//   An accepted byte waits in the input register until the queue has room, is
//   then parsed and written to the queue, from which its MIDI bytes are read.
//   Throughput: one packet byte per cycle while the eight-entry result queue
//   has room for three bytes; the rsp side drains one byte per cycle, so the
//   output port sets the sustained rate when bytes expand.
//   Reset clears the parser to expect a packet header, empties the queue and
//   drops any byte held in the input register.
//   When the receiver stalls, the queue fills; once it cannot take three more
//   bytes the input register holds its byte and req_stall rises.
// ============================================================================
module ble_midi_packet_decoder_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_packet_byte,
   input  wire logic       req_packet_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_midi_byte,
   output logic            rsp_last_of_run
);
   import bmd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_end_ff;
   logic              accept;
   logic              advance;
   logic              pop;
   result_bundle_type results;
   fifo_status_type   fifo_status;

   // Input register: parsed as soon as the queue has room.
   assign advance   = in_valid_ff && fifo_status.room;
   assign req_stall = in_valid_ff && !fifo_status.room;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      if (accept)       in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_packet_byte;
         in_end_ff  <= req_packet_end;
      end
   end

   bmd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .packet_byte (in_byte_ff),
      .packet_end  (in_end_ff),
      .results     (results)
   );

   bmd_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_byte  (rsp_midi_byte),
      .out_last  (rsp_last_of_run),
      .status    (fifo_status)
   );

`ifndef SYNTHESIS
   // The queue never holds more than its depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // Bytes are only released while the queue can take a full bundle.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (results.count != '0) |-> fifo_status.room)
      else $error("bytes released without queue room");

   // Without a push or a pop the fill level holds.
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      (results.count == '0 && !pop) |=> $stable(fifo_status.level))
      else $error("queue level moved without traffic");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/bmd_decode.sv
`default_nettype none
// ============================================================================
// BLE-MIDI byte parser
// Holds the packet parse state and turns one packet byte into up to three
// MIDI bytes.
// ============================================================================
module bmd_decode (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       fire,
   input  wire logic [7:0]                 packet_byte,
   input  wire logic                       packet_end,
   output bmd_pkg::result_bundle_type      results
);
   import bmd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] rs_ff, rs_in;
   logic [1:0] left_ff, left_in;
   logic [6:0] held_ff, held_in;

   result_bundle_type res;
   logic              hi;
   logic [1:0]        n_byte;
   logic [1:0]        n_rs;
   logic [1:0]        left_dec;

   assign hi       = packet_byte[7];
   assign n_byte   = data_count(packet_byte);
   assign n_rs     = rs_ff[7] ? data_count(rs_ff) : DCNT_NONE;
   assign left_dec = left_ff - 2'd1;

   // Next state and released bytes for the byte in the input register.
   always_comb begin
      phase_in  = phase_ff;
      rs_in     = rs_ff;
      left_in   = left_ff;
      held_in   = held_ff;
      res.count = '0;
      res.bytes = '0;
      case (phase_ff)
         PH_HEADER: begin
            phase_in = hi ? PH_TSTAMP : PH_DROP;
         end
         PH_DROP: begin
         end
         PH_TSTAMP: begin
            if (hi) phase_in = PH_STATUS;
         end
         PH_STATUS: begin
            if (!hi) begin
               // Data byte in status position: expand the running status.
               phase_in = PH_TSTAMP;
               if (n_rs == DCNT_ONE) begin
                  res.count    = RES_CNT_W'(2);
                  res.bytes[0] = rs_ff;
                  res.bytes[1] = packet_byte;
               end else if (n_rs == DCNT_TWO && !packet_end) begin
                  held_in  = packet_byte[6:0];
                  phase_in = PH_RS_SECOND;
               end
            end else begin
               res.count    = RES_CNT_W'(1);
               res.bytes[0] = packet_byte;
               if (packet_byte < SYSEX_START) rs_in = packet_byte;
               else if (packet_byte != SYSEX_END) rs_in = '0;
               if (n_byte == DCNT_SYSEX) begin
                  phase_in = PH_SYSEX;
               end else if (n_byte != DCNT_NONE) begin
                  left_in  = n_byte;
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_TSTAMP;
               end
            end
         end
         PH_DATA: begin
            if (hi) begin
               // Early stop: this byte is a timestamp.
               left_in  = '0;
               phase_in = PH_STATUS;
            end else begin
               res.count    = RES_CNT_W'(1);
               res.bytes[0] = packet_byte;
               left_in      = left_dec;
               if (left_dec == 2'd0) phase_in = PH_TSTAMP;
            end
         end
         PH_RS_SECOND: begin
            res.count    = RES_CNT_W'(3);
            res.bytes[0] = rs_ff;
            res.bytes[1] = {1'b0, held_ff};
            res.bytes[2] = packet_byte;
            phase_in     = PH_TSTAMP;
         end
         PH_SYSEX: begin
            res.count    = RES_CNT_W'(1);
            res.bytes[0] = packet_byte;
            if (packet_byte == SYSEX_END) phase_in = PH_TSTAMP;
         end
         default: begin
         end
      endcase
      // The end of a packet abandons any unfinished message.
      if (packet_end) begin
         phase_in = PH_HEADER;
         left_in  = '0;
      end
   end

   // Released bytes only count when the byte is actually processed.
   always_comb begin
      results       = res;
      results.count = fire ? res.count : '0;
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         rs_ff    <= '0;
         left_ff  <= '0;
         held_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         rs_ff    <= rs_in;
         left_ff  <= left_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/bmd_result_fifo.sv
`default_nettype none
// ============================================================================
// BLE-MIDI result queue
// Takes up to three MIDI bytes a cycle and hands out one beat a cycle when popped.
// ============================================================================
module bmd_result_fifo (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bmd_pkg::result_bundle_type push,
   input  wire logic                       pop,
   output logic                            out_valid,
   output logic [7:0]                      out_byte,
   output logic                            out_last,
   output bmd_pkg::fifo_status_type        status
);
   import bmd_pkg::*;

   logic [7:0]            data_mem [FIFO_DEPTH];
   logic                  last_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0] level_ff, level_in;

   // Pointer and fill level bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      level_in  = level_ff + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry writes; the last byte of a bundle carries the last flag.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (RES_CNT_W'(i) < push.count) begin
            data_mem[wr_ptr_ff + FIFO_PTR_W'(i)] <= push.bytes[i];
            last_mem[wr_ptr_ff + FIFO_PTR_W'(i)] <= (RES_CNT_W'(i + 1) == push.count);
         end
      end
   end

   assign out_valid    = (level_ff != '0);
   assign out_byte     = data_mem[rd_ptr_ff];
   assign out_last     = last_mem[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.room  = (level_ff <= FIFO_LVL_W'(FIFO_DEPTH - MAX_RESULTS));

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// BLE-MIDI packet decoder testbench
// Feeds directed and random BLE-MIDI packets into the decoder one beat at a
// time. A local decode of every accepted byte predicts the MIDI bytes that
// must come back. Random gaps on the input and random stalls on the output
// run in several phases.
// ============================================================================
module tb;
   import bmd_pkg::*;

   // One decoded MIDI byte waiting to come back from the block.
   typedef struct {
      logic [7:0] midi;
      logic       last;
   } midi_beat_type;

   // One row of the directed script. When known is set, the row carries its
   // own expectation (zero or one MIDI byte) instead of the local decode's.
   typedef struct {
      logic [7:0] pkt_byte;
      logic       pkt_end;
      bit         known;
      int         known_count;
      logic [7:0] known_midi;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_packet_byte = 8'h00;
   logic       req_packet_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_midi_byte;
   logic       rsp_last_of_run;

   // Decoder state mirrored by the testbench.
   phase_type  dec_phase;
   logic [7:0] dec_running;
   logic [1:0] dec_left;
   logic [6:0] dec_held;

   midi_beat_type  pending_midi[$];
   script_row_type script[$];
   int             bytes_sent = 0;
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;

   ble_midi_packet_decoder_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_packet_byte (req_packet_byte),
      .req_packet_end  (req_packet_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_midi_byte   (rsp_midi_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Number of data bytes that follow a status byte.
   function automatic logic [1:0] msg_data_len(input logic [7:0] s);
      logic [1:0] len;
      case (s[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = DCNT_TWO;
         4'hC, 4'hD:                   len = DCNT_ONE;
         default: begin
            case (s)
               SYSEX_START:               len = DCNT_SYSEX;
               TIME_CODE_QF, SONG_SELECT: len = DCNT_ONE;
               SONG_POSITION:             len = DCNT_TWO;
               default:                   len = DCNT_NONE;
            endcase
         end
      endcase
      return len;
   endfunction

   // Advances the mirrored parser by one packet byte and returns the MIDI
   // bytes that it releases, in order.
   task automatic decode_packet_byte(input logic [7:0] b, input logic e,
                                     output logic [2:0][7:0] outv, output int n);
      logic [1:0] len;
      n = 0;
      outv = '0;
      case (dec_phase)
         PH_HEADER: begin
            dec_phase = b[7] ? PH_TSTAMP : PH_DROP;
         end
         PH_TSTAMP: begin
            if (b[7]) dec_phase = PH_STATUS;
         end
         PH_STATUS: begin
            if (!b[7]) begin
               // Data byte in status position: expand the running status.
               len = dec_running[7] ? msg_data_len(dec_running) : DCNT_NONE;
               dec_phase = PH_TSTAMP;
               if (len == DCNT_ONE) begin
                  outv[0] = dec_running;
                  outv[1] = b;
                  n = 2;
               end else if (len == DCNT_TWO && !e) begin
                  dec_held = b[6:0];
                  dec_phase = PH_RS_SECOND;
               end
            end else begin
               len = msg_data_len(b);
               outv[0] = b;
               n = 1;
               if (b < SYSEX_START) dec_running = b;
               else if (b != SYSEX_END) dec_running = 8'h00;
               if (len == DCNT_SYSEX) begin
                  dec_phase = PH_SYSEX;
               end else if (len != DCNT_NONE) begin
                  dec_left = len;
                  dec_phase = PH_DATA;
               end else begin
                  dec_phase = PH_TSTAMP;
               end
            end
         end
         PH_DATA: begin
            if (b[7]) begin
               // Early stop: the byte is a timestamp.
               dec_left = 2'd0;
               dec_phase = PH_STATUS;
            end else begin
               outv[0] = b;
               n = 1;
               dec_left = dec_left - 2'd1;
               if (dec_left == 2'd0) dec_phase = PH_TSTAMP;
            end
         end
         PH_RS_SECOND: begin
            outv[0] = dec_running;
            outv[1] = {1'b0, dec_held};
            outv[2] = b;
            n = 3;
            dec_phase = PH_TSTAMP;
         end
         PH_SYSEX: begin
            outv[0] = b;
            n = 1;
            if (b == SYSEX_END) dec_phase = PH_TSTAMP;
         end
         default: begin
         end
      endcase
      if (e) begin
         dec_phase = PH_HEADER;
         dec_left = 2'd0;
      end
   endtask

   // Drives one packet byte, waits for its beat and queues what it releases.
   // Entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic e, input bit known,
                            input int known_count, input logic [7:0] known_midi);
      logic [2:0][7:0] outv;
      int              n;
      int              i;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_packet_byte <= b;
      req_packet_end <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_packet_byte(b, e, outv, n);
      if (known) begin
         n = known_count;
         outv[0] = known_midi;
      end
      for (i = 0; i < n; i++) pending_midi.push_back('{outv[i], i == n - 1});
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic void add_row(input logic [7:0] b, input logic e, input bit known,
                                   input int known_count, input logic [7:0] known_midi);
      script.push_back('{b, e, known, known_count, known_midi});
   endfunction

   function automatic logic [7:0] rand_data();
      return 8'($urandom_range(127));
   endfunction

   // Builds one packet: mostly well-formed timestamp and message pairs with
   // random content, with some noise, early stops and cut packets mixed in.
   task automatic send_random_packet();
      logic [7:0] pkt[$];
      logic [7:0] s;
      int         msg_total;
      int         kind;
      int         d;
      int         m;
      int         i;
      if ($urandom_range(9) == 0) pkt.push_back(rand_data());
      else pkt.push_back(8'h80 | rand_data());
      msg_total = $urandom_range(1, 4);
      for (m = 0; m < msg_total; m++) begin
         if ($urandom_range(9) == 0) pkt.push_back(rand_data());
         pkt.push_back(8'h80 | rand_data());
         kind = $urandom_range(99);
         if (kind < 45) begin
            s = 8'(8'h80 + $urandom_range(111));
            pkt.push_back(s);
            d = (msg_data_len(s) == DCNT_ONE) ? 1 : 2;
            if ($urandom_range(7) == 0) d--;
            for (i = 0; i < d; i++) pkt.push_back(rand_data());
         end else if (kind < 60) begin
            // Running status: data bytes straight after the timestamp.
            d = $urandom_range(1, 2);
            for (i = 0; i < d; i++) pkt.push_back(rand_data());
            if ($urandom_range(3) == 0) pkt.push_back(8'h80 | rand_data());
         end else if (kind < 72) begin
            case ($urandom_range(5))
               0:       s = TIME_CODE_QF;
               1:       s = SONG_POSITION;
               2:       s = SONG_SELECT;
               3:       s = 8'hF4;
               4:       s = 8'hF5;
               default: s = 8'hF6;
            endcase
            pkt.push_back(s);
            d = int'(msg_data_len(s));
            if ($urandom_range(7) == 0 && d > 0) d--;
            for (i = 0; i < d; i++) pkt.push_back(rand_data());
         end else if (kind < 82) begin
            pkt.push_back(SYSEX_START);
            d = $urandom_range(4);
            for (i = 0; i < d; i++) pkt.push_back(rand_data());
            if ($urandom_range(7) != 0) pkt.push_back(SYSEX_END);
         end else if (kind < 90) begin
            pkt.push_back(8'(8'hF8 + $urandom_range(7)));
         end else begin
            d = $urandom_range(1, 3);
            for (i = 0; i < d; i++) pkt.push_back(8'($urandom_range(255)));
         end
      end
      // Now and then the packet is cut short, mid message or earlier.
      if ($urandom_range(7) == 0) begin
         d = $urandom_range(1, pkt.size());
         while (pkt.size() > d) void'(pkt.pop_back());
      end
      for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, 0, 8'h00);
   endtask

   // Receiver stalls, changed at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compares every result beat with the oldest expectation.
   always @(posedge clock) begin
      midi_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_midi.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected MIDI byte %02h last %0b", $time,
                        rsp_midi_byte, rsp_last_of_run);
         end else begin
            want = pending_midi.pop_front();
            if (rsp_midi_byte !== want.midi || rsp_last_of_run !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: MIDI byte %02h last %0b, expected %02h last %0b", $time,
                           rsp_midi_byte, rsp_last_of_run, want.midi, want.last);
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int row;
      int p;
      int target;
      dec_phase = PH_HEADER;
      dec_running = 8'h00;
      dec_left = 2'd0;
      dec_held = 7'd0;

      // Packet with notes, running status, an early stop, exclusive and a
      // dropped data byte where no running status is kept.
      add_row(8'h80, 1'b0, 1'b1, 0, 8'h00);
      add_row(8'h80, 1'b0, 1'b1, 0, 8'h00);
      add_row(8'h90, 1'b0, 1'b1, 1, 8'h90);
      add_row(8'h00, 1'b0, 1'b1, 1, 8'h00);
      add_row(8'h7F, 1'b0, 1'b1, 1, 8'h7F);
      add_row(8'h85, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'h40, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'hFF, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'h81, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'hC5, 1'b0, 1'b1, 1, 8'hC5);
      add_row(8'h81, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'h05, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'h82, 1'b0, 1'b0, 0, 8'h00);
      add_row(SYSEX_START, 1'b0, 1'b1, 1, SYSEX_START);
      add_row(8'h01, 1'b0, 1'b0, 0, 8'h00);
      add_row(SYSEX_END, 1'b0, 1'b1, 1, SYSEX_END);
      add_row(8'h83, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'hF4, 1'b0, 1'b1, 1, 8'hF4);
      add_row(8'h84, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'h05, 1'b1, 1'b1, 0, 8'h00);
      // Short packet with a bad header.
      add_row(8'h7F, 1'b0, 1'b1, 0, 8'h00);
      add_row(8'hF8, 1'b1, 1'b1, 0, 8'h00);
      // Running status of two data bytes cut by the packet end.
      add_row(8'hFF, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'hFF, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'hEF, 1'b0, 1'b1, 1, 8'hEF);
      add_row(8'h80, 1'b0, 1'b0, 0, 8'h00);
      add_row(8'h7F, 1'b1, 1'b0, 0, 8'h00);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < script.size(); row++)
         send_byte(script[row].pkt_byte, script[row].pkt_end, script[row].known,
                   script[row].known_count, script[row].known_midi);

      // Random packets in four idling phases.
      for (p = 0; p < 4; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 48; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         target = bytes_sent + 75;
         while (bytes_sent < target) send_random_packet();
      end
      req_valid <= 1'b0;

      while (pending_midi.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
